### src/irs_pkg.sv
`default_nettype none

package irs_pkg;

	// result status codes
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_SLASHES     = 3'd1;
	localparam logic [2:0] ST_COLONS      = 3'd2;
	localparam logic [2:0] ST_TWO_AT      = 3'd3;
	localparam logic [2:0] ST_DIGEST      = 3'd4;
	localparam logic [2:0] ST_TAG_COLONS  = 3'd5;
	localparam logic [2:0] ST_TOO_LONG    = 3'd6;

	// delimiter characters
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_DOT   = 8'h2E;

	// counter limits
	localparam logic [2:0] SLASH_LIMIT = 3'd4;
	localparam logic [1:0] COLON_LIMIT = 2'd3;

endpackage

`default_nettype wire

### src/image_reference_splitter.sv
// Image reference splitter.
//
// Input channel (in_valid / in_ready): one character of a container image
// reference per transfer, left to right, with is_last set on the final one.
// Output channel (out_valid / out_ready): one result per reference, giving a
// status and the offsets of registry, namespace, repository, tag, digest
// algorithm and digest. Absent parts read as start = end = 0; on any error
// every field but status is zero.
//
// Throughput: one character per cycle across reference borders, while no
// final character waits for a free result slot. The result passes the input
// register, the result snapshot register and the output register in turn.
//
// Reset clears the scan state and all valid flags; no result is pending.
// When the receiver stalls, the output register holds its result and the
// snapshot stage can hold one more. Characters that are not final keep
// flowing; a final character waits in the input register only when both
// result slots are full.
`default_nettype none

module image_reference_splitter
	import irs_pkg::*;
#(
	parameter int MAX_REF_LEN = 4096
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [7:0]           ref_byte,
	input  wire logic                 is_last,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [2:0]                status,
	output logic                      registry_default,
	output logic [$clog2(MAX_REF_LEN+1)-1:0] registry_end,
	output logic [$clog2(MAX_REF_LEN+1)-1:0] user_start,
	output logic [$clog2(MAX_REF_LEN+1)-1:0] user_end,
	output logic [$clog2(MAX_REF_LEN+1)-1:0] repo_start,
	output logic [$clog2(MAX_REF_LEN+1)-1:0] repo_end,
	output logic [$clog2(MAX_REF_LEN+1)-1:0] tag_start,
	output logic [$clog2(MAX_REF_LEN+1)-1:0] tag_end,
	output logic [$clog2(MAX_REF_LEN+1)-1:0] algo_start,
	output logic [$clog2(MAX_REF_LEN+1)-1:0] algo_end,
	output logic [$clog2(MAX_REF_LEN+1)-1:0] digest_start
);

	// offsets run 0..MAX_REF_LEN, counter saturates at MAX_REF_LEN
	localparam int POS_W = $clog2(MAX_REF_LEN + 1);
	localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_REF_LEN);

	typedef logic [POS_W-1:0] pos_t;

	// running scan state for the reference in flight
	typedef struct packed {
		pos_t       pos;
		logic [2:0] slashes;
		pos_t       first_slash;
		pos_t       last_slash;
		logic [1:0] colons;
		pos_t       last_colon;
		pos_t       prior_colon;
		logic       at_seen;
		pos_t       at_pos;
		logic       dot_first;
		logic [2:0] err;
	} scan_t;

	typedef struct packed {
		logic [2:0] status;
		logic       reg_dflt;
		pos_t       reg_end;
		pos_t       user_s;
		pos_t       user_e;
		pos_t       repo_s;
		pos_t       repo_e;
		pos_t       tag_s;
		pos_t       tag_e;
		pos_t       algo_s;
		pos_t       algo_e;
		pos_t       dig_s;
	} result_t;

	// ---------------- handshake / stage control ----------------
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       valid_s2;
	scan_t      snap_s2;
	scan_t      scan_q;
	scan_t      scan_nxt;
	result_t    res;
	result_t    res_q;

	logic out_free;
	logic s2_free;
	logic s1_adv;
	logic s2_load;
	logic s2_move;
	logic in_xfer;

	assign out_free = !out_valid || out_ready;
	assign s2_free  = !valid_s2 || out_free;
	// only a final character needs a free snapshot slot
	assign s1_adv   = !last_s1 || s2_free;
	assign in_ready = !valid_s1 || s1_adv;
	assign in_xfer  = in_valid && in_ready;
	assign s2_load  = valid_s1 && last_s1 && s2_free;
	assign s2_move  = valid_s2 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			out_valid <= 1'b0;
			scan_q    <= '0;
		end else begin
			valid_s1  <= in_xfer || (valid_s1 && !s1_adv);
			valid_s2  <= s2_load || (valid_s2 && !out_free);
			out_valid <= s2_move || (out_valid && !out_ready);
			if (valid_s1 && s1_adv) begin
				// a final character hands its state to the snapshot and restarts the scan
				scan_q <= last_s1 ? '0 : scan_nxt;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1 <= ref_byte;
			last_s1 <= is_last;
		end
		if (s2_load) begin
			snap_s2 <= scan_nxt;
		end
		if (s2_move) begin
			res_q <= res;
		end
	end

	// ---------------- per-character scan update ----------------
	always_comb begin
		scan_nxt = scan_q;
		if (scan_q.err == ST_OK) begin
			if (scan_q.pos >= MAX_POS) begin
				// past the length limit: character not examined
				scan_nxt.err = ST_TOO_LONG;
			end else begin
				case (byte_s1)
					CH_SLASH: begin
						if (scan_q.slashes >= SLASH_LIMIT) begin
							scan_nxt.err = ST_SLASHES;
						end else begin
							if (scan_q.slashes == 3'd0) begin
								scan_nxt.first_slash = scan_q.pos;
							end
							scan_nxt.last_slash = scan_q.pos;
							scan_nxt.slashes    = scan_q.slashes + 3'd1;
						end
					end
					CH_COLON: begin
						if (scan_q.colons >= COLON_LIMIT) begin
							scan_nxt.err = ST_COLONS;
						end else begin
							scan_nxt.prior_colon = scan_q.last_colon;
							scan_nxt.last_colon  = scan_q.pos;
							scan_nxt.colons      = scan_q.colons + 2'd1;
						end
					end
					CH_AT: begin
						if (scan_q.at_seen) begin
							scan_nxt.err = ST_TWO_AT;
						end else begin
							scan_nxt.at_seen = 1'b1;
							scan_nxt.at_pos  = scan_q.pos;
						end
					end
					CH_DOT: begin
						if (scan_q.slashes == 3'd0) begin
							scan_nxt.dot_first = 1'b1;
						end
					end
					default: ;
				endcase
			end
		end
		if (scan_q.pos < MAX_POS) begin
			scan_nxt.pos = scan_q.pos + 1'b1;
		end
	end

	// ---------------- result decode from the snapshot ----------------
	function automatic pos_t span_s(input pos_t s, input pos_t e);
		span_s = (e > s) ? s : '0;
	endfunction

	function automatic pos_t span_e(input pos_t s, input pos_t e);
		span_e = (e > s) ? e : '0;
	endfunction

	pos_t base;
	pos_t bound;
	pos_t user_from;
	pos_t tag_from;
	pos_t algo_from;
	pos_t colon_after;
	logic has_slash;
	logic tag_in_digest;
	logic colon_excess;
	logic tag_plain;
	logic [2:0] colon_cap;

	always_comb begin
		has_slash     = (snap_s2.slashes != 3'd0);
		base          = has_slash ? snap_s2.last_slash + 1'b1 : '0;
		bound         = has_slash ? snap_s2.last_slash : '0;
		user_from     = snap_s2.first_slash + 1'b1;
		tag_from      = snap_s2.prior_colon + 1'b1;
		algo_from     = snap_s2.at_pos + 1'b1;
		colon_after   = snap_s2.last_colon + 1'b1;
		tag_in_digest = (snap_s2.colons >= 2'd2) && (snap_s2.prior_colon > bound)
		                && (snap_s2.prior_colon < snap_s2.at_pos);
		// two colons without a slash, three with one, leave no room for a tag alone
		colon_cap     = has_slash ? 3'd3 : 3'd2;
		colon_excess  = ({1'b0, snap_s2.colons} >= colon_cap);
		tag_plain     = (snap_s2.colons != 2'd0) && (snap_s2.last_colon > bound);

		res = '0;
		if (snap_s2.err != ST_OK) begin
			res.status = snap_s2.err;
		end else if (snap_s2.at_seen &&
		             ((snap_s2.colons == 2'd0) || (snap_s2.last_colon < snap_s2.at_pos))) begin
			res.status = ST_DIGEST;
		end else if (!snap_s2.at_seen && colon_excess) begin
			res.status = ST_TAG_COLONS;
		end else begin
			res.status = ST_OK;
			// registry and namespace
			if (!has_slash) begin
				res.reg_dflt = 1'b1;
			end else if (snap_s2.slashes >= 3'd2) begin
				res.reg_end = snap_s2.first_slash;
				res.user_s  = span_s(user_from, snap_s2.last_slash);
				res.user_e  = span_e(user_from, snap_s2.last_slash);
			end else if (snap_s2.dot_first) begin
				res.reg_end = snap_s2.last_slash;
			end else begin
				// single slash, no dot: leading text is a namespace
				res.reg_dflt = 1'b1;
				res.user_s   = span_s('0, snap_s2.last_slash);
				res.user_e   = span_e('0, snap_s2.last_slash);
			end
			// repository, tag, digest
			if (snap_s2.at_seen) begin
				res.algo_s = span_s(algo_from, snap_s2.last_colon);
				res.algo_e = span_e(algo_from, snap_s2.last_colon);
				res.dig_s  = colon_after;
				if (tag_in_digest) begin
					res.tag_s  = span_s(tag_from, snap_s2.at_pos);
					res.tag_e  = span_e(tag_from, snap_s2.at_pos);
					res.repo_s = span_s(base, snap_s2.prior_colon);
					res.repo_e = span_e(base, snap_s2.prior_colon);
				end else begin
					res.repo_s = span_s(base, snap_s2.at_pos);
					res.repo_e = span_e(base, snap_s2.at_pos);
				end
			end else if (tag_plain) begin
				res.tag_s  = span_s(colon_after, snap_s2.pos);
				res.tag_e  = span_e(colon_after, snap_s2.pos);
				res.repo_s = span_s(base, snap_s2.last_colon);
				res.repo_e = span_e(base, snap_s2.last_colon);
			end else begin
				res.repo_s = span_s(base, snap_s2.pos);
				res.repo_e = span_e(base, snap_s2.pos);
			end
		end
	end

	assign status           = res_q.status;
	assign registry_default = res_q.reg_dflt;
	assign registry_end     = res_q.reg_end;
	assign user_start       = res_q.user_s;
	assign user_end         = res_q.user_e;
	assign repo_start       = res_q.repo_s;
	assign repo_end         = res_q.repo_e;
	assign tag_start        = res_q.tag_s;
	assign tag_end          = res_q.tag_e;
	assign algo_start       = res_q.algo_s;
	assign algo_end         = res_q.algo_e;
	assign digest_start     = res_q.dig_s;

endmodule

`default_nettype wire

### src/irs_checker.sv
`default_nettype none

module irs_checker
	import irs_pkg::*;
#(
	parameter int MAX_REF_LEN = 4096
) (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire logic [2:0]           status,
	input wire logic                 registry_default,
	input wire logic [$clog2(MAX_REF_LEN+1)-1:0] registry_end,
	input wire logic [$clog2(MAX_REF_LEN+1)-1:0] user_start,
	input wire logic [$clog2(MAX_REF_LEN+1)-1:0] user_end,
	input wire logic [$clog2(MAX_REF_LEN+1)-1:0] repo_start,
	input wire logic [$clog2(MAX_REF_LEN+1)-1:0] repo_end,
	input wire logic [$clog2(MAX_REF_LEN+1)-1:0] tag_start,
	input wire logic [$clog2(MAX_REF_LEN+1)-1:0] tag_end,
	input wire logic [$clog2(MAX_REF_LEN+1)-1:0] algo_start,
	input wire logic [$clog2(MAX_REF_LEN+1)-1:0] algo_end,
	input wire logic [$clog2(MAX_REF_LEN+1)-1:0] digest_start
);

	// stalled result must hold
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(repo_end)
		&& $stable(tag_end) && $stable(digest_start))
		else $error("result changed while stalled");

	// error results carry nothing but the status
	a_err_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> !registry_default && registry_end == '0
		&& user_start == '0 && user_end == '0 && repo_start == '0 && repo_end == '0
		&& tag_start == '0 && tag_end == '0 && algo_start == '0 && algo_end == '0
		&& digest_start == '0)
		else $error("error result with nonzero fields");

	// spans never run backwards
	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> user_start <= user_end && repo_start <= repo_end
		&& tag_start <= tag_end && algo_start <= algo_end)
		else $error("span end before start");

	// default hub means no registry text
	a_dflt_reg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && registry_default |-> registry_end == '0)
		else $error("registry text with default hub");

endmodule

bind image_reference_splitter irs_checker #(.MAX_REF_LEN(MAX_REF_LEN)) u_irs_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.status           (status),
	.registry_default (registry_default),
	.registry_end     (registry_end),
	.user_start       (user_start),
	.user_end         (user_end),
	.repo_start       (repo_start),
	.repo_end         (repo_end),
	.tag_start        (tag_start),
	.tag_end          (tag_end),
	.algo_start       (algo_start),
	.algo_end         (algo_end),
	.digest_start     (digest_start)
);

`default_nettype wire
